@@ rtl/tifs_pkg.sv @@
// Shared types, constants and helper functions for the text integer field scanner.
// No dependencies; every other file uses this package.
package tifs_pkg;

  localparam int LONG_BITS  = 64;

  localparam int CHAR_W     = 8;
  localparam int VALUE_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int END_W      = 2;
  localparam int COUNT_W    = 8;
  localparam int BASE_W     = 2;
  localparam int SIZE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIG_W      = 5;
  localparam int PROD_W     = VALUE_W + 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LF_HEX = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  localparam logic [DIG_W-1:0] DIG_BAD = 5'd31;

  typedef enum logic [BASE_W-1:0] {
    BASE_AUTO, BASE_OCT, BASE_DEC, BASE_HEX
  } base_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_OVERFLOW, ST_NO_DIGITS
  } status_e;

  typedef enum logic [END_W-1:0] {
    END_TERM, END_WIDTH, END_TEXT
  } end_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_MODE, REG_SIGNED_MODE, REG_TARGET_SIZE, REG_MAX_WIDTH
  } reg_e;

  typedef enum logic [SIZE_W-1:0] {
    SIZE_CHAR, SIZE_SHORT, SIZE_INT, SIZE_LONG, SIZE_LLONG
  } size_e;

  // Controller to datapath
  typedef struct packed {
    logic  load_char;
    logic  set_sign;
    logic  set_base;
    base_e base_val;
    logic  mac_a;
    logic  mac_zero;
    logic  mac_b;
    logic  set_pfx;
    logic  finish;
    end_e  fin_end;
    logic  fin_use_char;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  is_ws;
    logic  is_sign;
    logic  is_zero;
    logic  is_x;
    logic  is_nul;
    logic  dig_ok;
    logic  width_hit;
    logic  out_free;
    base_e base_mode;
  } st_t;

  function automatic logic [DIG_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [DIG_W-1:0] d;
    d = DIG_BAD;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIG_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      d = DIG_W'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = DIG_W'(c - CH_UA + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [DIG_W-1:0] radix_of(input base_e b);
    logic [DIG_W-1:0] r;
    unique case (b)
      BASE_OCT: r = 5'd8;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

  // long_umax: unsigned maximum of the long type
  function automatic logic [VALUE_W-1:0] type_max(input logic sgn,
                                                  input logic [SIZE_W-1:0] size,
                                                  input logic [VALUE_W-1:0] long_umax);
    logic [VALUE_W-1:0] m;
    unique case (size)
      SIZE_CHAR:  m = sgn ? 64'h7F : 64'hFF;
      SIZE_SHORT: m = sgn ? 64'h7FFF : 64'hFFFF;
      SIZE_INT:   m = sgn ? 64'h7FFF_FFFF : 64'hFFFF_FFFF;
      SIZE_LONG:  m = sgn ? (long_umax >> 1) : long_umax;
      default:    m = sgn ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/tifs_intf.sv @@
// Valid/ready channel interfaces: character input, result output, register writes.
// Depends on tifs_pkg for field widths.
interface tifs_char_if;
  logic                          valid;
  logic                          ready;
  logic [tifs_pkg::CHAR_W-1:0]   char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tifs_result_if;
  logic                           valid;
  logic                           ready;
  logic [tifs_pkg::VALUE_W-1:0]   value_bits;
  logic [tifs_pkg::STATUS_W-1:0]  status;
  logic [tifs_pkg::END_W-1:0]     ended_by;
  logic [tifs_pkg::CHAR_W-1:0]    stop_char;
  logic [tifs_pkg::COUNT_W-1:0]   digit_count;

  modport source (output valid, output value_bits, output status, output ended_by,
                  output stop_char, output digit_count, input ready);
  modport sink   (input valid, input value_bits, input status, input ended_by,
                  input stop_char, input digit_count, output ready);
endinterface

interface tifs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tifs_pkg::CFG_IDX_W-1:0]   index;
  logic [tifs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tifs_dpath.sv @@
// Datapath: config registers, character register, accumulator with two-step
// multiply-accumulate and overflow check, result register. Uses tifs_pkg.
module tifs_dpath #(
  parameter int LONG_BITS = tifs_pkg::LONG_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tifs_pkg::cmd_t                  cmd_i,
  output tifs_pkg::st_t                   st_o,
  input  logic [tifs_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                            cfg_we_i,
  input  logic [tifs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tifs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output logic [tifs_pkg::VALUE_W-1:0]    value_bits_o,
  output logic [tifs_pkg::STATUS_W-1:0]   status_o,
  output logic [tifs_pkg::END_W-1:0]      ended_by_o,
  output logic [tifs_pkg::CHAR_W-1:0]     stop_char_o,
  output logic [tifs_pkg::COUNT_W-1:0]    digit_count_o
);
  import tifs_pkg::*;

  localparam logic [VALUE_W-1:0] LONG_UMAX = {VALUE_W{1'b1}} >> (VALUE_W - LONG_BITS);

  base_e               base_mode_q;
  logic                signed_mode_q;
  logic [SIZE_W-1:0]   target_size_q;
  logic [COUNT_W-1:0]  max_width_q;

  logic [CHAR_W-1:0]   char_q;
  logic [VALUE_W-1:0]  acc_q;
  logic                neg_q;
  logic                ovf_q;
  logic [COUNT_W-1:0]  digits_q;
  base_e               active_base_q;

  logic [PROD_W-1:0]   prod_q;
  logic [3:0]          dig_q;
  logic [VALUE_W-1:0]  lim_q;

  logic                res_valid_q;
  logic [VALUE_W-1:0]  value_q;
  status_e             status_q;
  end_e                ended_q;
  logic [CHAR_W-1:0]   stop_q;
  logic [COUNT_W-1:0]  count_q;

  logic [VALUE_W-1:0]  tmax;
  logic [VALUE_W-1:0]  cur_lim;
  logic [DIG_W-1:0]    char_dig;
  logic [PROD_W-1:0]   prod_d;
  logic [PROD_W-1:0]   sum;
  logic                sum_over;
  logic [VALUE_W-1:0]  fin_mag;
  logic [VALUE_W-1:0]  fin_val;
  logic                out_free;

  assign tmax     = type_max(signed_mode_q, target_size_q, LONG_UMAX);
  assign cur_lim  = (signed_mode_q && neg_q) ? tmax + 64'd1 : tmax;
  assign char_dig = digit_of(char_q);

  // acc * radix as shifts plus at most one add
  always_comb begin
    unique case (active_base_q)
      BASE_HEX: prod_d = {acc_q, 4'b0000};
      BASE_OCT: prod_d = {1'b0, acc_q, 3'b000};
      default:  prod_d = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
    endcase
  end

  // acc*b + d > limit  <=>  acc > (limit - d) / b
  assign sum      = prod_q + {{(PROD_W-4){1'b0}}, dig_q};
  assign sum_over = sum > {4'b0000, lim_q};

  assign fin_mag  = ovf_q ? cur_lim : acc_q;
  assign fin_val  = (digits_q == '0) ? '0 :
                    (signed_mode_q && neg_q) ? (64'd0 - fin_mag) : fin_mag;

  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    st_o.is_ws     = (char_q == CH_SPACE) || (char_q == CH_TAB) ||
                     (char_q == CH_LF) || (char_q == CH_CR);
    st_o.is_sign   = (char_q == CH_PLUS) || (char_q == CH_MINUS);
    st_o.is_zero   = (char_q == CH_0);
    st_o.is_x      = (char_q == CH_LX) || (char_q == CH_UX);
    st_o.is_nul    = (char_q == CH_NUL);
    st_o.dig_ok    = char_dig < radix_of(active_base_q);
    st_o.width_hit = (max_width_q != '0) && (digits_q >= max_width_q);
    st_o.out_free  = out_free;
    st_o.base_mode = base_mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q   <= BASE_DEC;
      signed_mode_q <= 1'b1;
      target_size_q <= SIZE_INT;
      max_width_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_BASE_MODE:   base_mode_q   <= base_e'(cfg_data_i[BASE_W-1:0]);
        REG_SIGNED_MODE: signed_mode_q <= cfg_data_i[0];
        REG_TARGET_SIZE: target_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_MAX_WIDTH:   max_width_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      neg_q         <= 1'b0;
      ovf_q         <= 1'b0;
      digits_q      <= '0;
      active_base_q <= BASE_AUTO;
    end else if (cmd_i.finish) begin
      acc_q         <= '0;
      neg_q         <= 1'b0;
      ovf_q         <= 1'b0;
      digits_q      <= '0;
      active_base_q <= BASE_AUTO;
    end else begin
      if (cmd_i.set_sign) neg_q <= (char_q == CH_MINUS);
      if (cmd_i.set_base) active_base_q <= cmd_i.base_val;
      if (cmd_i.set_pfx) begin
        active_base_q <= BASE_HEX;
        digits_q      <= 8'd2;
      end
      if (cmd_i.mac_b) begin
        if (sum_over) begin
          ovf_q <= 1'b1;
        end else if (!ovf_q) begin
          acc_q <= sum[VALUE_W-1:0];
        end
        if (digits_q != '1) digits_q <= digits_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_char) char_q <= char_code_i;
    if (cmd_i.mac_a) begin
      prod_q <= prod_d;
      dig_q  <= cmd_i.mac_zero ? 4'd0 : char_dig[3:0];
      lim_q  <= cur_lim;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      value_q  <= fin_val;
      status_q <= (digits_q == '0) ? ST_NO_DIGITS : (ovf_q ? ST_OVERFLOW : ST_OK);
      ended_q  <= cmd_i.fin_end;
      stop_q   <= cmd_i.fin_use_char ? char_q : CH_NUL;
      count_q  <= digits_q;
    end
  end

  assign res_valid_o   = res_valid_q;
  assign value_bits_o  = value_q;
  assign status_o      = status_q;
  assign ended_by_o    = ended_q;
  assign stop_char_o   = stop_q;
  assign digit_count_o = count_q;

endmodule

@@ rtl/tifs_ctrl.sv @@
// Controller: per-character sequencer for the scan phases, pending leading zero
// and field end. Drives tifs_dpath through cmd_t / st_t from tifs_pkg.
module tifs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           char_valid_i,
  output logic           char_ready_o,
  input  tifs_pkg::st_t  st_i,
  output tifs_pkg::cmd_t cmd_o
);
  import tifs_pkg::*;

  typedef enum logic [2:0] {
    S_WAIT, S_EVAL, S_DCHAR, S_MACB, S_TDONE, S_WCHK, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_SIGN, PH_DIGITS
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   zp_q, zp_d;
  logic   pend_q, pend_d;
  end_e   end_q, end_d;
  logic   use_char_q, use_char_d;
  logic   first_char;

  assign char_ready_o = (state_q == S_WAIT);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    zp_d       = zp_q;
    pend_d     = pend_q;
    end_d      = end_q;
    use_char_d = use_char_q;
    cmd_o      = '0;
    first_char = 1'b0;

    unique case (state_q)
      S_WAIT: begin
        if (char_valid_i) begin
          cmd_o.load_char = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (phase_q == PH_IDLE && st_i.is_ws) begin
          state_d = S_WAIT;
        end else if (phase_q == PH_IDLE && st_i.is_sign) begin
          cmd_o.set_sign = 1'b1;
          phase_d        = PH_SIGN;
          state_d        = S_WAIT;
        end else if (phase_q != PH_DIGITS) begin
          first_char = 1'b1;
        end else if (zp_q) begin
          zp_d = 1'b0;
          if (st_i.is_x) begin
            cmd_o.set_pfx = 1'b1;
            state_d       = S_WCHK;
          end else begin
            // the held zero is a real digit; the current char follows it
            cmd_o.mac_a    = 1'b1;
            cmd_o.mac_zero = 1'b1;
            pend_d         = 1'b1;
            state_d        = S_MACB;
          end
        end else begin
          state_d = S_DCHAR;
        end

        if (first_char) begin
          phase_d        = PH_DIGITS;
          cmd_o.set_base = 1'b1;
          if (st_i.is_zero && (st_i.base_mode == BASE_AUTO || st_i.base_mode == BASE_HEX)) begin
            zp_d           = 1'b1;
            cmd_o.base_val = (st_i.base_mode == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            state_d        = S_WAIT;
          end else begin
            cmd_o.base_val = (st_i.base_mode == BASE_AUTO) ? BASE_DEC : st_i.base_mode;
            state_d        = S_DCHAR;
          end
        end
      end
      S_DCHAR: begin
        if (!st_i.dig_ok) begin
          end_d      = st_i.is_nul ? END_TEXT : END_TERM;
          use_char_d = !st_i.is_nul;
          state_d    = S_FIN;
        end else begin
          cmd_o.mac_a = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_MACB;
        end
      end
      S_MACB: begin
        cmd_o.mac_b = 1'b1;
        state_d     = S_TDONE;
      end
      S_TDONE: begin
        if (st_i.width_hit) begin
          end_d      = END_WIDTH;
          use_char_d = 1'b0;
          pend_d     = 1'b0;
          state_d    = S_FIN;
        end else if (pend_q) begin
          pend_d  = 1'b0;
          state_d = S_DCHAR;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WCHK: begin
        if (st_i.width_hit) begin
          end_d      = END_WIDTH;
          use_char_d = 1'b0;
          state_d    = S_FIN;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.finish       = 1'b1;
          cmd_o.fin_end      = end_q;
          cmd_o.fin_use_char = use_char_q;
          phase_d            = PH_IDLE;
          zp_d               = 1'b0;
          state_d            = S_WAIT;
        end
      end
      default: state_d = S_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_WAIT;
      phase_q    <= PH_IDLE;
      zp_q       <= 1'b0;
      pend_q     <= 1'b0;
      end_q      <= END_TERM;
      use_char_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      zp_q       <= zp_d;
      pend_q     <= pend_d;
      end_q      <= end_d;
      use_char_q <= use_char_d;
    end
  end

endmodule

@@ rtl/text_integer_field_scanner.sv @@
// Text integer field scanner: ASCII characters in, one scanned integer out per field.
// Top level; instantiates tifs_ctrl and tifs_dpath, uses tifs_pkg and the channel
// interfaces in tifs_intf.sv.
//
// Usage:
//   char_i   - one ASCII character per transaction; 0 marks end of text.
//   result_o - one transaction per finished field: value, status, what ended it,
//              the stop character and the count of digit characters taken.
//   cfg_i    - register writes (0 base mode, 1 signed mode, 2 target size,
//              3 max width); always ready, write only between fields.
// Per character: each character is worked on to the end before the next is taken.
//   Whitespace, sign or a held leading zero go through S_EVAL only; the x of 0x also
//   through S_WCHK. A digit goes through S_DCHAR, S_MACB and S_TDONE (two-step
//   shift-add multiply-accumulate and limit compare). A terminator goes through
//   S_DCHAR to S_FIN, where the result register loads. A held zero that turns out to
//   be a digit can send two digits through the accumulator. Reaching the width adds S_FIN.
// The result sits in an output register; the next field's characters are taken
//   while it waits. Only when a second result is ready and the receiver still
//   stalls does the scanner hold at that field's end and stop taking characters.
// Reset: config returns to decimal, signed, int bounds, unlimited width; the
//   scan restarts skipping whitespace and no result is pending.
module text_integer_field_scanner #(
  parameter int LONG_BITS = tifs_pkg::LONG_BITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  tifs_char_if.sink     char_i,
  tifs_result_if.source result_o,
  tifs_cfg_if.sink      cfg_i
);
  import tifs_pkg::*;

  cmd_t cmd;
  st_t  st;

  assign cfg_i.ready = 1'b1;

  tifs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_i.valid),
    .char_ready_o (char_i.ready),
    .st_i         (st),
    .cmd_o        (cmd)
  );

  tifs_dpath #(
    .LONG_BITS (LONG_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .char_code_i   (char_i.char_code),
    .cfg_we_i      (cfg_i.valid),
    .cfg_idx_i     (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .res_ready_i   (result_o.ready),
    .res_valid_o   (result_o.valid),
    .value_bits_o  (result_o.value_bits),
    .status_o      (result_o.status),
    .ended_by_o    (result_o.ended_by),
    .stop_char_o   (result_o.stop_char),
    .digit_count_o (result_o.digit_count)
  );

endmodule

@@ tb/sv/tifs_checker.sv @@
// Checker for the text integer field scanner: watches the config, character and
// result channels, predicts each finished field and compares it with the result.
// Depends on tifs_pkg for widths and codes.
module tifs_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [tifs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tifs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            char_valid_i,
  input  logic                            char_ready_i,
  input  logic [tifs_pkg::CHAR_W-1:0]     char_code_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [tifs_pkg::VALUE_W-1:0]    res_value_i,
  input  logic [tifs_pkg::STATUS_W-1:0]   res_status_i,
  input  logic [tifs_pkg::END_W-1:0]      res_ended_i,
  input  logic [tifs_pkg::CHAR_W-1:0]     res_stop_i,
  input  logic [tifs_pkg::COUNT_W-1:0]    res_count_i,
  output int                              errors_o,
  output int                              pending_o,
  output int                              fields_o
);
  import tifs_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_AFTER_SIGN, SCAN_DIGITS} scan_e;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    status_e            status;
    end_e               ended_by;
    logic [CHAR_W-1:0]  stop_char;
    logic [COUNT_W-1:0] digit_count;
  } field_t;

  // register copies
  base_e              base_sel;
  logic               signed_sel;
  logic [SIZE_W-1:0]  size_sel;
  logic [COUNT_W-1:0] width_sel;

  // field in progress
  scan_e              scan;
  logic [VALUE_W-1:0] acc;
  logic               neg, ovf, zero_held;
  logic [COUNT_W-1:0] ndig;
  base_e              field_base;

  field_t pending_fields [$];

  function automatic logic [VALUE_W-1:0] bound_max();
    logic [VALUE_W-1:0] u;
    case (size_sel)
      SIZE_CHAR:  u = 64'hFF;
      SIZE_SHORT: u = 64'hFFFF;
      SIZE_INT:   u = 64'hFFFF_FFFF;
      SIZE_LONG:  u = {VALUE_W{1'b1}} >> (VALUE_W - LONG_BITS);
      default:    u = {VALUE_W{1'b1}};
    endcase
    return signed_sel ? (u >> 1) : u;
  endfunction

  function automatic logic [VALUE_W-1:0] limit_now();
    return (signed_sel && neg) ? bound_max() + 64'd1 : bound_max();
  endfunction

  function automatic logic [VALUE_W-1:0] radix_now();
    case (field_base)
      BASE_OCT: return 64'd8;
      BASE_HEX: return 64'd16;
      default:  return 64'd10;
    endcase
  endfunction

  function automatic logic [4:0] char_digit(logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF_HEX) return 5'(c - CH_LA) + 5'd10;
    if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA) + 5'd10;
    return 5'd31;
  endfunction

  function automatic bit width_done();
    return width_sel != 0 && ndig >= width_sel;
  endfunction

  function automatic void close_field(end_e how, logic [CHAR_W-1:0] stop);
    field_t f;
    logic [VALUE_W-1:0] mag;
    f.value_bits = '0;
    f.status     = ST_NO_DIGITS;
    if (ndig != 0) begin
      f.status = ovf ? ST_OVERFLOW : ST_OK;
      if (signed_sel) begin
        // saturate toward the sign that was given
        mag = ovf ? (neg ? limit_now() : bound_max()) : acc;
        f.value_bits = neg ? (64'd0 - mag) : mag;
      end else begin
        f.value_bits = ovf ? bound_max() : acc;
      end
    end
    f.ended_by    = how;
    f.stop_char   = stop;
    f.digit_count = ndig;
    pending_fields.push_back(f);
    scan       = SCAN_IDLE;
    acc        = '0;
    neg        = 1'b0;
    ovf        = 1'b0;
    zero_held  = 1'b0;
    ndig       = '0;
    field_base = BASE_AUTO;
  endfunction

  function automatic bit add_digit(logic [4:0] d);
    logic [VALUE_W-1:0] r;
    r = radix_now();
    if (acc > (limit_now() - 64'(d)) / r) begin
      ovf = 1'b1;
    end else if (!ovf) begin
      acc = acc * r + 64'(d);
    end
    if (ndig != 8'd255) ndig = ndig + 8'd1;
    if (width_done()) begin
      close_field(END_WIDTH, CH_NUL);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void digit_or_end(logic [CHAR_W-1:0] c);
    logic [4:0] d;
    d = char_digit(c);
    if (64'(d) >= radix_now()) begin
      if (c == CH_NUL) close_field(END_TEXT, CH_NUL);
      else close_field(END_TERM, c);
    end else begin
      void'(add_digit(d));
    end
  endfunction

  function automatic void start_digits(logic [CHAR_W-1:0] c);
    scan = SCAN_DIGITS;
    if (c == CH_0 && (base_sel == BASE_AUTO || base_sel == BASE_HEX)) begin
      // hold the zero until the next character tells whether 0x follows
      zero_held  = 1'b1;
      field_base = (base_sel == BASE_AUTO) ? BASE_OCT : BASE_HEX;
      return;
    end
    field_base = (base_sel == BASE_AUTO) ? BASE_DEC : base_sel;
    digit_or_end(c);
  endfunction

  function automatic void scan_char(logic [CHAR_W-1:0] c);
    case (scan)
      SCAN_IDLE: begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) return;
        if (c == CH_MINUS || c == CH_PLUS) begin
          neg  = (c == CH_MINUS);
          scan = SCAN_AFTER_SIGN;
          return;
        end
        start_digits(c);
      end
      SCAN_AFTER_SIGN: start_digits(c);
      default: begin
        if (zero_held) begin
          zero_held = 1'b0;
          if (c == CH_LX || c == CH_UX) begin
            field_base = BASE_HEX;
            ndig       = 8'd2;
            if (width_done()) close_field(END_WIDTH, CH_NUL);
            return;
          end
          // the held zero was a digit; if it fills the width, c is dropped
          if (add_digit(5'd0)) return;
        end
        digit_or_end(c);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    field_t f;
    if (!rst_ni) begin
      base_sel   = BASE_DEC;
      signed_sel = 1'b1;
      size_sel   = SIZE_INT;
      width_sel  = '0;
      scan       = SCAN_IDLE;
      acc        = '0;
      neg        = 1'b0;
      ovf        = 1'b0;
      zero_held  = 1'b0;
      ndig       = '0;
      field_base = BASE_AUTO;
      pending_fields.delete();
      errors_o   = 0;
      fields_o   = 0;
      pending_o  = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_BASE_MODE:   base_sel   = base_e'(cfg_data_i[BASE_W-1:0]);
          REG_SIGNED_MODE: signed_sel = cfg_data_i[0];
          REG_TARGET_SIZE: size_sel   = cfg_data_i[SIZE_W-1:0];
          REG_MAX_WIDTH:   width_sel  = cfg_data_i;
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        if (pending_fields.size() == 0) begin
          $error("unexpected result: value_bits %h status %0d", res_value_i, res_status_i);
          errors_o++;
        end else begin
          f = pending_fields.pop_front();
          if (res_value_i !== f.value_bits) begin
            $error("value_bits: expected %h, got %h", f.value_bits, res_value_i);
            errors_o++;
          end
          if (res_status_i !== f.status) begin
            $error("status: expected %0d, got %0d", f.status, res_status_i);
            errors_o++;
          end
          if (res_ended_i !== f.ended_by) begin
            $error("ended_by: expected %0d, got %0d", f.ended_by, res_ended_i);
            errors_o++;
          end
          if (res_stop_i !== f.stop_char) begin
            $error("stop_char: expected %h, got %h", f.stop_char, res_stop_i);
            errors_o++;
          end
          if (res_count_i !== f.digit_count) begin
            $error("digit_count: expected %0d, got %0d", f.digit_count, res_count_i);
            errors_o++;
          end
          fields_o++;
        end
      end
      if (char_valid_i && char_ready_i) scan_char(char_code_i);
      pending_o = pending_fields.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Top of the scanner testbench: clock, reset, character and register stimulus,
// result backpressure, watchdog and verdict. Depends on tifs_pkg, tifs_intf.sv,
// tifs_checker and the text_integer_field_scanner RTL.
module tb;
  import tifs_pkg::*;

  localparam int CHAR_TARGET   = 1450;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 20;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tifs_char_if   char_if();
  tifs_result_if res_if();
  tifs_cfg_if    cfg_if();

  int    errors, pending, fields;
  int    chars_sent = 0;
  int    settings = 0;
  int    burst_left = 0;
  bit    gappy = 1'b1;
  base_e cur_base = BASE_DEC;

  text_integer_field_scanner DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  tifs_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_index_i  (cfg_if.index),
    .cfg_data_i   (cfg_if.data),
    .char_valid_i (char_if.valid),
    .char_ready_i (char_if.ready),
    .char_code_i  (char_if.char_code),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_value_i  (res_if.value_bits),
    .res_status_i (res_if.status),
    .res_ended_i  (res_if.ended_by),
    .res_stop_i   (res_if.stop_char),
    .res_count_i  (res_if.digit_count),
    .errors_o     (errors),
    .pending_o    (pending),
    .fields_o     (fields)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: switches between no stall, random stalls and long stalls.
  initial begin
    int unsigned mode_left, run_left, mode;
    bit run_val;
    mode_left = 0;
    run_left  = 0;
    mode      = 0;
    run_val   = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end
      mode_left--;
      case (mode)
        0: res_if.ready <= 1'b1;
        1: res_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            run_val  = !run_val;
            run_left = run_val ? $urandom_range(1, 4) : $urandom_range(3, 25);
          end
          run_left--;
          res_if.ready <= run_val;
        end
      endcase
    end
  end

  // Watchdog: ends the run once no transaction has happened for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((char_if.valid && char_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_char(input logic [CHAR_W-1:0] c);
    if (burst_left == 0) begin
      if (gappy) begin
        char_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    do @(posedge clk_i); while (!char_if.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Four register writes back to back; valid drops only after the last one.
  task automatic load_config(input logic [7:0] base_v, sgn_v, size_v, width_v);
    reg_e       idx [4];
    logic [7:0] val [4];
    idx = '{REG_BASE_MODE, REG_SIGNED_MODE, REG_TARGET_SIZE, REG_MAX_WIDTH};
    val = '{base_v, sgn_v, size_v, width_v};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    cfg_if.valid <= 1'b0;
    cur_base = base_e'(base_v[BASE_W-1:0]);
    settings++;
  endtask

  // Wait until every field has come back and the scanner has settled.
  task automatic drain();
    char_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] pick_space();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_x();
    return $urandom_range(0, 1) ? CH_LX : CH_UX;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_digit(input base_e b);
    int unsigned v;
    case (b)
      BASE_OCT: v = $urandom_range(0, 7);
      BASE_HEX: v = $urandom_range(0, 15);
      default:  v = $urandom_range(0, 9);
    endcase
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  // One field: mostly well formed with random content, some raw noise.
  task automatic send_field();
    base_e       gen;
    int unsigned ndig;
    string       seps;
    seps = ",;)gz.";
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2)) send_char(pick_space());
    case ($urandom_range(0, 5))
      0: send_char(CH_MINUS);
      1: send_char(CH_PLUS);
      2: begin
        send_char(CH_MINUS);
        if ($urandom_range(0, 3) == 0) send_char(CH_PLUS);
      end
      default: ;
    endcase
    gen = cur_base;
    case (cur_base)
      BASE_AUTO: begin
        case ($urandom_range(0, 2))
          0: begin
            send_char(CH_0);
            send_char(pick_x());
            gen = BASE_HEX;
          end
          1: begin
            send_char(CH_0);
            gen = BASE_OCT;
          end
          default: gen = BASE_DEC;
        endcase
      end
      BASE_HEX: begin
        if ($urandom_range(0, 1) == 0) begin
          send_char(CH_0);
          send_char(pick_x());
        end
      end
      default: if ($urandom_range(0, 3) == 0) send_char(CH_0);
    endcase
    if ($urandom_range(0, 9) == 0) ndig = 0;
    else if ($urandom_range(0, 4) == 0) ndig = $urandom_range(7, 24);
    else ndig = $urandom_range(1, 6);
    repeat (ndig) send_char(pick_digit(gen));
    case ($urandom_range(0, 4))
      0: send_char(CH_NUL);
      1: send_char(8'($urandom_range(0, 255)));
      2: send_char(CH_SPACE);
      default: send_char(seps[$urandom_range(0, seps.len() - 1)]);
    endcase
  endtask

  initial begin
    int unsigned span, first;
    logic [7:0]  bv, sv, zv, wv;
    char_if.valid     <= 1'b0;
    char_if.char_code <= CH_NUL;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_BASE_MODE;
    cfg_if.data       <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: whitespace, signed value, sign then whitespace, odd
    // byte as terminator, end of text while idle.
    send_text(" \t\n\r-12;+ ");
    send_char(8'hFF);
    send_char(CH_NUL);
    drain();
    // auto base with width 3: hex prefix counts toward width; leading-zero octal
    load_config(8'(BASE_AUTO), 8'd1, 8'(SIZE_INT), 8'd3);
    send_text("0x7012");
    drain();
    // width 1: prefix overshoots the width; held zero fills it, next char dropped
    load_config(8'(BASE_HEX), 8'd0, 8'(SIZE_LLONG), 8'd1);
    send_text("0x05");
    drain();
    // negative overflow of a signed char
    load_config(8'(BASE_DEC), 8'd1, 8'(SIZE_CHAR), 8'd0);
    send_text("-999");
    send_char(CH_NUL);
    drain();

    while (chars_sent < CHAR_TARGET) begin
      if (settings == 4) begin
        bv = 8'(BASE_AUTO);
        sv = 8'd0;
        zv = 8'(SIZE_CHAR);
        wv = 8'd255;
      end else if (settings == 5) begin
        bv = 8'(BASE_HEX);
        sv = 8'd1;
        zv = 8'd7;
        wv = 8'd0;
      end else begin
        // upper data bits are random; the scanner keeps only the field bits
        bv = {6'($urandom), 2'($urandom_range(0, 3))};
        sv = {7'($urandom), 1'($urandom_range(0, 1))};
        zv = {5'($urandom), 3'($urandom_range(0, 2) == 0 ? $urandom_range(5, 7)
                                                          : $urandom_range(0, 4))};
        case ($urandom_range(0, 5))
          0: wv = 8'd255;
          1: wv = 8'($urandom_range(1, 3));
          2: wv = 8'($urandom_range(4, 24));
          default: wv = 8'd0;
        endcase
      end
      load_config(bv, sv, zv, wv);
      gappy = ($urandom_range(0, 3) != 0);
      span  = $urandom_range(40, 120);
      first = chars_sent;
      while (chars_sent - first < span) send_field();
      send_char(CH_NUL);
      drain();
    end

    @(negedge clk_i);
    $display("Sent %0d characters under %0d register settings.", chars_sent, settings);
    $display("Checked %0d scanned fields against the prediction.", fields);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
